// ===== hw/rtl/puct_pkg.sv =====
// Shared constants and types for the PUCT child selection block.
package puct_pkg;

    localparam int MAX_CHILDREN = 256;
    localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W        = 8;
    localparam int SCORE_W      = 28;
    localparam int ALU_W        = 27;
    localparam int STEP_W       = 5;

    localparam int SQRT_STEPS   = 24;
    localparam int UDIV_STEPS   = 29;
    localparam int QDIV_STEPS   = 31;

    localparam logic [15:0] EXPLORE_RESET = 16'd4096;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_MUL1,
        S_MUL2,
        S_UDIV,
        S_QDIV,
        S_SCORE,
        S_EMIT
    } t_state;

endpackage

// ===== hw/rtl/puct_child_select_top.sv =====
// PUCT child scoring and running argmax over the children of one node.
//
// Each child word keeps the block busy from the edge that accepts it until it
// is scored, so a new child word is not taken before the last one is through.
// A word carrying tlast then passes through an emit state that loads the
// result register, and waits there while that register still holds an
// unaccepted word. The work is done by one shared 27-bit subtractor that runs,
// in turn, a 24-step square root of the parent count, a 29-step division of
// the exploration product by (1 + child visits) and a 31-step division of
// the scaled value sum by the child visits; two registered multiplies sit
// between the root and the first division. The result word waits in an
// output register, so the next child is taken while it is pending. Ties keep
// the earliest child; children past MAX_CHILDREN in a group are passed over
// without scoring and only their tlast counts.
module puct_child_select_top
    import puct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] parent_visits, [39:16] child_value_sum, [55:40] child_visits,
    // [72:56] child_prior, [79:73] zero
    input  logic [79:0] i_s_tdata,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] best_index, [35:8] best_score, [39:36] zero
    output logic [39:0] o_m_tdata
);

    t_state r_state, n_state;

    logic [15:0]             r_explore;
    logic [23:0]             r_vabs;
    logic                    r_vneg;
    logic [15:0]             r_visits;
    logic [16:0]             r_prior;
    logic                    r_last;

    logic [ALU_W-1:0]        r_rem;
    logic [47:0]             r_src;
    logic [30:0]             r_quo;
    logic [16:0]             r_dvs;
    logic [STEP_W-1:0]       r_step;
    logic [23:0]             r_root;
    logic [32:0]             r_pc;
    logic [28:0]             r_u;

    logic [SCORE_W-1:0]      r_best;
    logic [CNT_W-1:0]        r_best_pos;
    logic [CNT_W-1:0]        r_count;
    logic                    r_have;

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic [SCORE_W-1:0]      r_out_score;

    logic                    in_acc;
    logic                    can_score;
    logic                    is_sqrt;
    logic [ALU_W-1:0]        alu_a;
    logic [ALU_W-1:0]        alu_b;
    logic [ALU_W:0]          alu_diff;
    logic                    alu_ge;
    logic [ALU_W-1:0]        alu_rem;
    logic [30:0]             quo_next;
    logic [56:0]             prod;
    logic signed [32:0]      q_val;
    logic signed [32:0]      s_val;
    logic [SCORE_W-1:0]      s_clamp;
    logic                    better;
    logic                    emit_go;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign can_score  = (r_count < CNT_W'(MAX_CHILDREN));
    assign emit_go    = !r_out_valid || i_m_tready;

    // Shared compare-and-subtract unit.
    assign is_sqrt = (r_state == S_SQRT);
    always_comb begin
        if (is_sqrt) begin
            alu_a = {r_rem[24:0], r_src[47:46]};
            alu_b = {1'b0, r_quo[23:0], 2'b01};
        end else begin
            alu_a = {9'b0, r_rem[16:0], r_src[47]};
            alu_b = {10'b0, r_dvs};
        end
    end
    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[ALU_W];
    assign alu_rem  = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
    assign quo_next = {r_quo[29:0], alu_ge};

    assign prod = 57'(r_pc) * 57'(r_root);

    // Score: q + u, clamped to the score range.
    always_comb begin
        if (r_visits == 16'd0) begin
            q_val = '0;
        end else if (r_vneg) begin
            q_val = 33'sd32768 - $signed({2'b0, r_quo})
                    - $signed({32'b0, (r_rem != '0)});
        end else begin
            q_val = 33'sd32768 + $signed({2'b0, r_quo});
        end
        s_val = q_val + $signed({4'b0, r_u});
        if (s_val[32]) begin
            s_clamp = '0;
        end else if (s_val[31:SCORE_W] != '0) begin
            s_clamp = '1;
        end else begin
            s_clamp = s_val[SCORE_W-1:0];
        end
        better = !r_have || (s_clamp > r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (can_score) begin
                        n_state = S_SQRT;
                    end else if (i_s_tlast) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SQRT:  if (r_step == '0) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_UDIV;
            S_UDIV:  if (r_step == '0) n_state = S_QDIV;
            S_QDIV:  if (r_step == '0) n_state = S_SCORE;
            S_SCORE: n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT:  if (emit_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_vneg   <= i_s_tdata[39];
                    r_vabs   <= i_s_tdata[39] ? 24'(-i_s_tdata[39:16]) : i_s_tdata[39:16];
                    r_visits <= i_s_tdata[55:40];
                    r_prior  <= i_s_tdata[72:56];
                    r_last   <= i_s_tlast;
                    r_src    <= {i_s_tdata[15:0], 32'b0};
                    r_rem    <= '0;
                    r_quo    <= '0;
                    r_step   <= STEP_W'(SQRT_STEPS - 1);
                end
            end
            S_SQRT: begin
                r_rem  <= alu_rem;
                r_quo  <= quo_next;
                r_src  <= {r_src[45:0], 2'b0};
                r_step <= r_step - 1'b1;
                r_root <= quo_next[23:0];
            end
            S_MUL1: begin
                r_pc <= 33'(r_prior) * 33'(r_explore);
            end
            S_MUL2: begin
                r_src  <= {prod[56:28], 19'b0};
                r_dvs  <= 17'(r_visits) + 17'd1;
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= STEP_W'(UDIV_STEPS - 1);
            end
            S_UDIV: begin
                if (r_step == '0) begin
                    r_u    <= quo_next[28] ? {1'b1, 28'b0} : quo_next[28:0];
                    r_src  <= {r_vabs, 7'b0, 17'b0};
                    r_dvs  <= {1'b0, r_visits};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_step <= STEP_W'(QDIV_STEPS - 1);
                end else begin
                    r_rem  <= alu_rem;
                    r_quo  <= quo_next;
                    r_src  <= {r_src[46:0], 1'b0};
                    r_step <= r_step - 1'b1;
                end
            end
            S_QDIV: begin
                r_rem  <= alu_rem;
                r_quo  <= quo_next;
                r_src  <= {r_src[46:0], 1'b0};
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Search state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_explore   <= EXPLORE_RESET;
            r_best      <= '0;
            r_best_pos  <= '0;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_explore <= i_cfg_wdata;
            end
            if (r_state == S_SCORE) begin
                if (better) begin
                    r_best     <= s_clamp;
                    r_best_pos <= r_count;
                    r_have     <= 1'b1;
                end
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= r_have ? IDX_W'(r_best_pos) : '0;
                r_out_score <= r_have ? r_best : '0;
                r_best      <= '0;
                r_best_pos  <= '0;
                r_count     <= '0;
                r_have      <= 1'b0;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_score, r_out_idx};

endmodule
